// File: rtl/bpc_pkg.sv
// ---------------------------------------------------------------------------
// bpc_pkg
// Shared types, register indexes and constants for the pressure compensation.
// ---------------------------------------------------------------------------
package bpc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // divider depth and the width of the side word carried through it
    localparam int DIV_STAGES = 16;
    localparam int DIV_SIDE_W = 32 + 1 + 1 + 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AC1_AC2  = 3'd0,
        REG_AC3_AC4  = 3'd1,
        REG_AC5_AC6  = 3'd2,
        REG_B1_B2    = 3'd3,
        REG_MC_MD    = 3'd4,
        REG_OSS      = 3'd5
    } reg_idx_t;

    localparam logic [31:0] K_B6_OFS  = 32'd4000;
    localparam logic [31:0] K_B7_SCL  = 32'd50000;
    localparam logic [31:0] K_P_X1    = 32'd3038;
    localparam logic [31:0] K_P_X2    = 32'd7357;
    localparam logic [31:0] K_P_OFS   = 32'd3791;
    localparam logic [31:0] K_B4_OFS  = 32'd32768;

    // Calibration words, sign or zero extended to 32 bits
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } cal_t;

    // Unsigned 32-bit quotient bundle for the pipelined divider
    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        neg;
    } div_req_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        asr32 = 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] h);
        sx16 = {{16{h[15]}}, h};
    endfunction

endpackage

// File: rtl/bpc_cfg.sv
// ---------------------------------------------------------------------------
// bpc_cfg
// Calibration register file; unpacks the words into extended coefficients.
// ---------------------------------------------------------------------------
module bpc_cfg
    import bpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cal_t                  cal
);

    logic [31:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_reg <= '0; r1_reg <= '0; r2_reg <= '0; r3_reg <= '0; r4_reg <= '0;
            oss_reg <= 2'd3;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_AC1_AC2: r0_reg <= cfg_data;
                REG_AC3_AC4: r1_reg <= cfg_data;
                REG_AC5_AC6: r2_reg <= cfg_data;
                REG_B1_B2:   r3_reg <= cfg_data;
                REG_MC_MD:   r4_reg <= cfg_data;
                REG_OSS:     oss_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.ac1 = sx16(r0_reg[31:16]);
        cal.ac2 = sx16(r0_reg[15:0]);
        cal.ac3 = sx16(r1_reg[31:16]);
        cal.ac4 = {16'd0, r1_reg[15:0]};
        cal.ac5 = {16'd0, r2_reg[31:16]};
        cal.ac6 = {16'd0, r2_reg[15:0]};
        cal.b1  = sx16(r3_reg[31:16]);
        cal.b2  = sx16(r3_reg[15:0]);
        cal.mc  = sx16(r4_reg[31:16]);
        cal.md  = sx16(r4_reg[15:0]);
        cal.oss = oss_reg;
    end

endmodule

// File: rtl/bpc_div.sv
// ---------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider, 32-bit unsigned, two quotient bits per stage.
// Carries an opaque side word alongside each beat; stalls with the pipe.
// ---------------------------------------------------------------------------
module bpc_div
    import bpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [31:0]           in_num,
    input  logic [31:0]           in_den,
    input  logic [DIV_SIDE_W-1:0] in_side,
    output logic                  out_vld,
    output logic [31:0]           out_quo,
    output logic [DIV_SIDE_W-1:0] out_side
);

    logic [31:0]           rem_reg  [DIV_STAGES];
    logic [31:0]           num_reg  [DIV_STAGES];
    logic [31:0]           den_reg  [DIV_STAGES];
    logic [DIV_SIDE_W-1:0] side_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;

    // one stage: shift two numerator bits into the remainder, subtract twice
    function automatic logic [63:0] step2(input logic [31:0] rem, input logic [31:0] num,
                                          input logic [31:0] den);
        logic [32:0] r;
        logic [31:0] n;
        r = {1'b0, rem};
        n = num;
        for (int k = 0; k < 2; k++) begin
            r = {r[31:0], n[31]};
            n = {n[30:0], 1'b0};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                n[0] = 1'b1;
            end
        end
        step2 = {r[31:0], n};
    endfunction

    logic [63:0] nx [DIV_STAGES];

    always_comb begin
        nx[0] = step2(32'd0, in_num, in_den);
        for (int s = 1; s < DIV_STAGES; s++) begin
            nx[s] = step2(rem_reg[s-1], num_reg[s-1], den_reg[s-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            {rem_reg[0], num_reg[0]} <= nx[0];
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int s = 1; s < DIV_STAGES; s++) begin
                {rem_reg[s], num_reg[s]} <= nx[s];
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_quo  = num_reg[DIV_STAGES-1];
    assign out_side = side_reg[DIV_STAGES-1];

endmodule

// File: rtl/barometric_pressure_temp_compensation.sv
// Throughput: one reading per cycle unless the result side stalls; two 16-stage
// pipelined dividers (temperature and pressure) and registered multiplier stages set the depth.
// A stall on the result side freezes the whole pipe; no beat is lost.
// Reset (synchronous, aresetn low) clears all valid bits, calibration
// registers to zero and oversampling to 3.
// ---------------------------------------------------------------------------
// barometric_pressure_temp_compensation
// Fixed-point temperature and pressure compensation, fully pipelined.
// ---------------------------------------------------------------------------
module barometric_pressure_temp_compensation
    import bpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [15:0]           s_raw_temp,
    input  logic [18:0]           s_raw_press,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_temp_tenths,
    output logic signed [31:0]    m_press_pa,
    output logic                  m_div_fault
);

    cal_t cal;
    logic en;

    bpc_cfg u_cfg (
        .aclk, .aresetn, .cfg_we, .cfg_idx, .cfg_data, .cal
    );

    // whole pipe advances when the output slot is free or being taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- temperature front end ----------------
    logic        a_vld_reg;
    logic [31:0] a_d_reg;
    logic [18:0] a_up_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) a_vld_reg <= 1'b0;
        else if (en) a_vld_reg <= s_valid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            a_d_reg  <= {16'd0, s_raw_temp} - cal.ac6;
            a_up_reg <= s_raw_press;
        end
    end

    logic        b_vld_reg;
    logic [31:0] b_prod_reg;
    logic [18:0] b_up_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) b_vld_reg <= 1'b0;
        else if (en) b_vld_reg <= a_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            b_prod_reg <= a_d_reg * cal.ac5;
            b_up_reg   <= a_up_reg;
        end
    end

    // x1, divisor, signed operands of mc<<11 / den
    logic [31:0] t_x1, t_den, t_num;
    assign t_x1  = asr32(b_prod_reg, 15);
    assign t_den = t_x1 + cal.md;
    assign t_num = cal.mc << 11;

    logic        c_vld_reg, c_fault_reg, c_neg_reg;
    logic [31:0] c_x1_reg, c_an_reg, c_ad_reg;
    logic [18:0] c_up_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) c_vld_reg <= 1'b0;
        else if (en) c_vld_reg <= b_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            c_x1_reg    <= t_x1;
            c_fault_reg <= (t_den == 32'd0);
            c_neg_reg   <= t_num[31] ^ t_den[31];
            c_an_reg    <= t_num[31] ? -t_num : t_num;
            c_ad_reg    <= t_den[31] ? -t_den : t_den;
            c_up_reg    <= b_up_reg;
        end
    end

    logic                  td_vld;
    logic [31:0]           td_quo;
    logic [DIV_SIDE_W-1:0] td_side;

    bpc_div u_tdiv (
        .aclk, .aresetn, .en,
        .in_vld  (c_vld_reg),
        .in_num  (c_an_reg),
        .in_den  (c_fault_reg ? 32'd1 : c_ad_reg),
        .in_side ({c_x1_reg, c_fault_reg, c_neg_reg, c_up_reg}),
        .out_vld (td_vld),
        .out_quo (td_quo),
        .out_side(td_side)
    );

    // ---------------- temperature result, b6 ----------------
    logic [31:0] d_x1;
    logic        d_fault, d_neg;
    logic [18:0] d_up;
    assign {d_x1, d_fault, d_neg, d_up} = td_side;

    logic [31:0] d_b5;
    assign d_b5 = d_x1 + (d_neg ? -td_quo : td_quo);

    logic        e_vld_reg, e_fault_reg;
    logic [31:0] e_temp_reg, e_b6_reg;
    logic [18:0] e_up_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) e_vld_reg <= 1'b0;
        else if (en) e_vld_reg <= td_vld;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            e_fault_reg <= d_fault;
            e_temp_reg  <= asr32(d_b5 + 32'd8, 4);
            e_b6_reg    <= d_b5 - K_B6_OFS;
            e_up_reg    <= d_up;
        end
    end

    // products on b6
    logic        f_vld_reg, f_fault_reg;
    logic [31:0] f_temp_reg, f_sq_reg, f_ac2b6_reg, f_ac3b6_reg;
    logic [18:0] f_up_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) f_vld_reg <= 1'b0;
        else if (en) f_vld_reg <= e_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            f_fault_reg <= e_fault_reg;
            f_temp_reg  <= e_temp_reg;
            f_sq_reg    <= e_b6_reg * e_b6_reg;
            f_ac2b6_reg <= cal.ac2 * e_b6_reg;
            f_ac3b6_reg <= cal.ac3 * e_b6_reg;
            f_up_reg    <= e_up_reg;
        end
    end

    logic [31:0] f_sq;
    assign f_sq = asr32(f_sq_reg, 12);

    logic        g_vld_reg, g_fault_reg;
    logic [31:0] g_temp_reg, g_b2sq_reg, g_b1sq_reg, g_ac2b6_reg, g_ac3b6_reg;
    logic [18:0] g_up_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) g_vld_reg <= 1'b0;
        else if (en) g_vld_reg <= f_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            g_fault_reg <= f_fault_reg;
            g_temp_reg  <= f_temp_reg;
            g_b2sq_reg  <= cal.b2 * f_sq;
            g_b1sq_reg  <= cal.b1 * f_sq;
            g_ac2b6_reg <= f_ac2b6_reg;
            g_ac3b6_reg <= f_ac3b6_reg;
            g_up_reg    <= f_up_reg;
        end
    end

    // b3 and x3 for b4
    logic [31:0] g_x3a, g_b3, g_x3b;
    assign g_x3a = asr32(g_b2sq_reg, 11) + asr32(g_ac2b6_reg, 11);
    assign g_b3  = asr32(((cal.ac1 * 32'd4 + g_x3a) << cal.oss) + 32'd2, 2);
    assign g_x3b = asr32(asr32(g_ac3b6_reg, 13) + asr32(g_b1sq_reg, 16) + 32'd2, 2);

    logic        h_vld_reg, h_fault_reg;
    logic [31:0] h_temp_reg, h_diff_reg, h_x3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) h_vld_reg <= 1'b0;
        else if (en) h_vld_reg <= g_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            h_fault_reg <= g_fault_reg;
            h_temp_reg  <= g_temp_reg;
            h_diff_reg  <= {13'd0, g_up_reg} - g_b3;
            h_x3_reg    <= g_x3b + K_B4_OFS;
        end
    end

    logic        i_vld_reg, i_fault_reg;
    logic [31:0] i_temp_reg, i_b4p_reg, i_b7_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) i_vld_reg <= 1'b0;
        else if (en) i_vld_reg <= h_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            i_fault_reg <= h_fault_reg;
            i_temp_reg  <= h_temp_reg;
            i_b4p_reg   <= cal.ac4 * h_x3_reg;
            i_b7_reg    <= h_diff_reg * (K_B7_SCL >> cal.oss);
        end
    end

    logic [31:0] i_b4;
    logic        i_big, i_fault;
    assign i_b4    = i_b4p_reg >> 15;
    assign i_fault = i_fault_reg || (i_b4 == 32'd0);
    assign i_big   = i_b7_reg[31];

    logic                  pd_vld;
    logic [31:0]           pd_quo;
    logic [DIV_SIDE_W-1:0] pd_side;

    // pad the side word; only the low 34 bits travel back out
    bpc_div u_pdiv (
        .aclk, .aresetn, .en,
        .in_vld  (i_vld_reg),
        .in_num  (i_big ? i_b7_reg : (i_b7_reg << 1)),
        .in_den  (i_fault ? 32'd1 : i_b4),
        .in_side ({19'd0, i_temp_reg, i_fault, i_big}),
        .out_vld (pd_vld),
        .out_quo (pd_quo),
        .out_side(pd_side)
    );

    logic [31:0] j_temp;
    logic        j_fault, j_big;
    assign j_temp  = pd_side[33:2];
    assign j_fault = pd_side[1];
    assign j_big   = pd_side[0];

    logic [31:0] j_p, j_ps;
    assign j_p  = j_big ? (pd_quo << 1) : pd_quo;
    assign j_ps = asr32(j_p, 8);

    logic        k_vld_reg, k_fault_reg;
    logic [31:0] k_temp_reg, k_p_reg, k_sq_reg, k_m_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) k_vld_reg <= 1'b0;
        else if (en) k_vld_reg <= pd_vld;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            k_fault_reg <= j_fault;
            k_temp_reg  <= j_temp;
            k_p_reg     <= j_p;
            k_sq_reg    <= j_ps * j_ps;
            k_m_reg     <= K_P_X2 * j_p;
        end
    end

    logic        l_vld_reg, l_fault_reg;
    logic [31:0] l_temp_reg, l_p_reg, l_x1_reg, l_x2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) l_vld_reg <= 1'b0;
        else if (en) l_vld_reg <= k_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            l_fault_reg <= k_fault_reg;
            l_temp_reg  <= k_temp_reg;
            l_p_reg     <= k_p_reg;
            l_x1_reg    <= k_sq_reg * K_P_X1;
            l_x2_reg    <= asr32(32'd0 - k_m_reg, 16);
        end
    end

    logic [31:0] l_press;
    assign l_press = l_p_reg + asr32(asr32(l_x1_reg, 16) + l_x2_reg + K_P_OFS, 4);

    // output register
    logic        out_vld_reg, out_fault_reg;
    logic [31:0] out_temp_reg, out_press_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en) out_vld_reg <= l_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            out_fault_reg <= l_fault_reg;
            out_temp_reg  <= l_fault_reg ? 32'd0 : l_temp_reg;
            out_press_reg <= l_fault_reg ? 32'd0 : l_press;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_div_fault   = out_fault_reg;
    assign m_temp_tenths = $signed(out_temp_reg);
    assign m_press_pa    = $signed(out_press_reg);

endmodule

// File: rtl/bpc_checker.sv
// ---------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the compensation block, bound to the top level.
// ---------------------------------------------------------------------------
module bpc_checker
    import bpc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_temp_tenths,
    input logic [31:0] m_press_pa,
    input logic        m_div_fault
);

    // a faulted beat carries zero results
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_fault |-> m_temp_tenths == 32'd0 && m_press_pa == 32'd0)
        else $error("fault beat with nonzero result");

    // input side is held only while a result is stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_press_pa) && $stable(m_div_fault))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");

endmodule

bind barometric_pressure_temp_compensation bpc_checker u_bpc_checker (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready,
    .m_temp_tenths, .m_press_pa, .m_div_fault
);

// File: verif/barometric_pressure_temp_compensation_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// barometric_pressure_temp_compensation_test
// Drives raw temperature and pressure readings through the compensation
// block under several calibration sets and oversampling settings. Each
// result beat is checked field by field against a compensation computed here.
// ---------------------------------------------------------------------------
module barometric_pressure_temp_compensation_test;
    import bpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
    localparam int PIPE_DEPTH = 43;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_READINGS = 1800;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic        fault;
    } reading_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [15:0]           s_raw_temp = '0;
    logic [18:0]           s_raw_press = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [31:0]    m_temp_tenths;
    logic signed [31:0]    m_press_pa;
    logic                  m_div_fault;

    logic [31:0] cal_word [0:4];
    logic [1:0]  oss_set;
    reading_t    pending_readings [$];
    int          errors = 0;
    int          readings_sent = 0;
    int          results_seen = 0;
    int          faults_seen = 0;
    bit          idle_on = 1'b0;
    int          quiet_cycles = 0;
    int          ready_hold = 0;

    barometric_pressure_temp_compensation dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_raw_temp(s_raw_temp), .s_raw_press(s_raw_press),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_temp_tenths(m_temp_tenths), .m_press_pa(m_press_pa),
        .m_div_fault(m_div_fault)
    );

    always #4 aclk = ~aclk;

    function automatic logic [31:0] ext16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic reading_t compensate(input logic [15:0] ut, input logic [18:0] up);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den;
        longint      q;
        reading_t    r;
        r = '{temp: 32'd0, press: 32'd0, fault: 1'b1};
        ac1 = ext16(cal_word[0][31:16]);
        ac2 = ext16(cal_word[0][15:0]);
        ac3 = ext16(cal_word[1][31:16]);
        ac4 = {16'd0, cal_word[1][15:0]};
        ac5 = {16'd0, cal_word[2][31:16]};
        ac6 = {16'd0, cal_word[2][15:0]};
        b1 = ext16(cal_word[3][31:16]);
        b2 = ext16(cal_word[3][15:0]);
        mc = ext16(cal_word[4][31:16]);
        md = ext16(cal_word[4][15:0]);

        x1 = sra(({16'd0, ut} - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 32'd0) return r;
        // 64-bit quotient keeps the most negative over minus one well defined
        q = longint'($signed(mc << 11)) / longint'($signed(den));
        x2 = q[31:0];
        b5 = x1 + x2;
        r.temp = sra(b5 + 32'd8, 4);

        b6 = b5 - K_B6_OFS;
        sq = sra(b6 * b6, 12);
        x1 = sra(b2 * sq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sra(((ac1 * 32'd4 + x3) << oss_set) + 32'd2, 2);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * sq, 16);
        x3 = sra(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + K_B4_OFS)) >> 15;
        if (b4 == 32'd0) begin
            r.temp = 32'd0;
            return r;
        end
        b7 = ({13'd0, up} - b3) * (K_B7_SCL >> oss_set);
        if (!b7[31]) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;

        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * K_P_X1, 16);
        x2 = sra(32'd0 - K_P_X2 * p, 16);
        r.press = p + sra(x1 + x2 + K_P_OFS, 4);
        r.fault = 1'b0;
        return r;
    endfunction

    // Result side: random back-pressure bursts while idling is on
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            ready_hold <= $urandom_range(1, 11) - 1;
        end else begin
            m_ready <= 1'b1;
            ready_hold <= idle_on ? $urandom_range(0, 15) : 0;
        end
    end

    always @(posedge aclk) begin
        reading_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_readings.size() == 0) begin
                $display("%0t: result beat with nothing expected: temp %0d press %0d fault %0b",
                         $time, m_temp_tenths, m_press_pa, m_div_fault);
                errors++;
            end else begin
                exp_r = pending_readings.pop_front();
                if (exp_r.fault) faults_seen++;
                if (m_temp_tenths !== exp_r.temp) begin
                    $display("%0t: temp_tenths expected %0d actual %0d",
                             $time, $signed(exp_r.temp), m_temp_tenths);
                    errors++;
                end
                if (m_press_pa !== exp_r.press) begin
                    $display("%0t: press_pa expected %0d actual %0d",
                             $time, $signed(exp_r.press), m_press_pa);
                    errors++;
                end
                if (m_div_fault !== exp_r.fault) begin
                    $display("%0t: div_fault expected %0b actual %0b",
                             $time, exp_r.fault, m_div_fault);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL barometric_pressure_temp_compensation");
            $finish;
        end
    end

    task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_temp <= ut;
        s_raw_press <= up;
        do @(posedge aclk); while (!s_ready);
        pending_readings.push_back(compensate(ut, up));
        readings_sent++;
    endtask

    // Drop valid and let every outstanding result drain
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge aclk);
        if (idx < REG_OSS) cal_word[idx] = data;
        else if (idx == REG_OSS) oss_set = data[1:0];
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_datasheet_cal(input logic [1:0] oss);
        write_reg(REG_AC1_AC2, {16'd408, 16'hFFB8});
        write_reg(REG_AC3_AC4, {16'hC7D1, 16'd32741});
        write_reg(REG_AC5_AC6, {16'd32757, 16'd23153});
        write_reg(REG_B1_B2, {16'd6190, 16'd4});
        write_reg(REG_MC_MD, {16'hDDF9, 16'd2868});
        write_reg(REG_OSS, {30'd0, oss});
    endtask

    task automatic test_reset_values();
        // all-zero calibration gives a zero temperature divisor
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        drain();
    endtask

    task automatic test_field_extremes();
        for (int o = 0; o < 4; o++) begin
            load_datasheet_cal(o[1:0]);
            send_reading(16'd27898, 19'd23843 << o);
            send_reading(16'd0, 19'd0);
            send_reading(16'hFFFF, 19'h7FFFF);
            send_reading(16'h8000, 19'h40000);
            drain();
        end
    endtask

    task automatic test_divisor_faults();
        logic [31:0] x1;
        load_datasheet_cal(2'd3);
        // zero pressure divisor: ac4 of zero
        write_reg(REG_AC3_AC4, {16'hC7D1, 16'd0});
        send_reading(16'd27898, 19'd23843);
        drain();
        // zero temperature divisor: md cancels x1 exactly
        write_reg(REG_AC3_AC4, {16'hC7D1, 16'd32741});
        x1 = sra((32'd27898 - 32'd23153) * 32'd32757, 15);
        write_reg(REG_MC_MD, {16'hDDF9, 16'(32'd0 - x1)});
        send_reading(16'd27898, 19'd23843);
        send_reading(16'd27899, 19'd23843);
        drain();
    endtask

    task automatic test_spare_index();
        load_datasheet_cal(2'd1);
        write_reg(IDX_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(IDX_SPARE_HI, 32'h0000_0000);
        write_reg(REG_OSS, 32'hFFFF_FFFC);  // only the low two bits stick
        send_reading(16'd27898, 19'd23843);
        drain();
    endtask

    task automatic load_random_cal();
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 5; i++) write_reg(i[2:0], $urandom());
        end else begin
            // realistic words nudged by a small random offset
            write_reg(REG_AC1_AC2, {16'(16'd408 + $urandom_range(0, 2000) - 1000),
                                    16'(16'hFFB8 + $urandom_range(0, 200) - 100)});
            write_reg(REG_AC3_AC4, {16'(16'hC7D1 + $urandom_range(0, 4000) - 2000),
                                    16'($urandom_range(20000, 40000))});
            write_reg(REG_AC5_AC6, {16'($urandom_range(24000, 40000)),
                                    16'($urandom_range(15000, 30000))});
            write_reg(REG_B1_B2, {16'($urandom_range(4000, 8000)),
                                  16'($urandom_range(0, 100))});
            write_reg(REG_MC_MD, {16'(16'hDDF9 + $urandom_range(0, 2000) - 1000),
                                  16'($urandom_range(1500, 4000))});
        end
        write_reg(REG_OSS, $urandom());
    endtask

    task automatic test_random_readings();
        int phase_len;
        int left;
        logic [15:0] ut;
        logic [18:0] up;
        left = RANDOM_READINGS;
        while (left > 0) begin
            load_random_cal();
            phase_len = $urandom_range(100, 300);
            if (left <= 300) idle_on = 1'b0;
            for (int n = 0; n < phase_len && left > 0; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    ut = 16'($urandom());
                    up = 19'($urandom());
                end else begin
                    ut = 16'($urandom_range(20000, 36000));
                    up = 19'($urandom_range(15000, 45000)) << oss_set;
                end
                send_reading(ut, up);
                left--;
                if (left == RANDOM_READINGS / 2) drain();
            end
            drain();
        end
    endtask

    initial begin
        for (int i = 0; i < 5; i++) cal_word[i] = 32'd0;
        oss_set = 2'd3;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;
        test_reset_values();
        test_field_extremes();
        test_divisor_faults();
        test_spare_index();
        test_random_readings();
        drain();
        $display("Covered %0d readings, %0d results, %0d with a divisor fault,",
                 readings_sent, results_seen, faults_seen);
        $display("across datasheet, nudged and random calibration at all oversampling settings.");
        if (errors == 0 && pending_readings.size() == 0) begin
            $display("PASS barometric_pressure_temp_compensation");
        end else begin
            $display("FAIL barometric_pressure_temp_compensation");
        end
        $finish;
    end

endmodule
